// File: hdl/cts_pkg.sv
// Shared widths, opcodes, status codes and task state codes for the task scheduler.
`default_nettype none

package cts_pkg;

    // Fixed field widths of the request and response beats
    localparam int OP_W     = 2;
    localparam int ID_W     = 6;
    localparam int STATUS_W = 4;
    localparam int STATE_W  = 2;

    // Largest table that a 6-bit id can address
    localparam int ID_SPACE = 1 << ID_W;

    // Default number of task ids
    localparam int NUM_TASKS_DEF = 64;

    typedef enum logic [OP_W-1:0] {
        OP_SCHEDULE = 2'd0,
        OP_START    = 2'd1,
        OP_FINISH   = 2'd2,
        OP_QUERY    = 2'd3
    } opcode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_RERUN_MARKED = 4'd0,
        ST_QUEUED       = 4'd1,
        ST_ALREADY      = 4'd2,
        ST_STARTED      = 4'd3,
        ST_QUEUE_EMPTY  = 4'd4,
        ST_FINISHED     = 4'd5,
        ST_RERUN        = 4'd6,
        ST_WORKER_BUSY  = 4'd7,
        ST_NOTHING_RUN  = 4'd8,
        ST_QUERY        = 4'd9
    } status_t;

    typedef enum logic [STATE_W-1:0] {
        TS_IDLE   = 2'd0,
        TS_QUEUED = 2'd1,
        TS_EXEC   = 2'd2,
        TS_RERUN  = 2'd3
    } task_state_t;

endpackage

`default_nettype wire

// File: hdl/coalescing_task_scheduler.sv
// Top level of the coalescing task scheduler: state table, worker slot and response buffer.
// Each request beat (opcode, task_id) is handled in the cycle it is accepted and
// answered by exactly one response beat (status, result_id, task_state) via the response
// register; one request per cycle is sustained while req_stall is low, limited by the
// update of the per-task queued flags, the worker slot and the id FIFO pointers. A response
// register plus a one-entry skid buffer let a request be taken while an earlier
// response waits; req_stall rises only when both are full. The running task's
// state (executing or rerun pending) lives in the worker slot, while each other
// id is either queued or idle, so reset clears everything at once with no clearing
// pass. Ids at or above NUM_TASKS name no task.
`default_nettype none

module coalescing_task_scheduler
    import cts_pkg::*;
#(
    parameter int NUM_TASKS = NUM_TASKS_DEF
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                req_valid,
    output logic                     req_stall,
    input  wire logic [OP_W-1:0]     opcode,
    input  wire logic [ID_W-1:0]     task_id,
    output logic                     rsp_valid,
    input  wire logic                rsp_stall,
    output logic      [STATUS_W-1:0] status,
    output logic      [ID_W-1:0]     result_id,
    output logic      [STATE_W-1:0]  task_state
);

    // Only ids that fit the id field can ever be used
    localparam int TABLE_SIZE = (NUM_TASKS < ID_SPACE) ? NUM_TASKS : ID_SPACE;
    localparam int IDX_W      = $clog2(TABLE_SIZE);

    typedef struct packed {
        status_t         status;
        logic [ID_W-1:0] id;
        task_state_t     state;
    } rsp_t;

    logic [TABLE_SIZE-1:0] queued_reg;
    logic                  running_valid_reg;
    logic                  rerun_reg;
    logic [IDX_W-1:0]      running_id_reg;

    rsp_t rsp_reg;
    rsp_t skid_reg;
    logic rsp_valid_reg;
    logic skid_valid_reg;

    logic             accept;
    logic             id_ok;
    logic [IDX_W-1:0] req_idx;
    logic             running_hit;
    logic             queued_hit;
    task_state_t      run_state;
    logic [IDX_W-1:0] fifo_head;
    logic             fifo_empty;
    logic             fifo_full;

    logic do_push;
    logic do_start;
    logic do_mark_rerun;
    logic do_rerun;
    logic do_stop;
    rsp_t rsp_new;

    assign accept    = req_valid && !req_stall;
    assign req_stall = skid_valid_reg;

    // Lookup of the requested id
    assign id_ok       = (32'(task_id) < NUM_TASKS);
    assign req_idx     = task_id[IDX_W-1:0];
    assign running_hit = running_valid_reg && (ID_W'(running_id_reg) == task_id);
    assign queued_hit  = queued_reg[req_idx];
    assign run_state   = rerun_reg ? TS_RERUN : TS_EXEC;

    // Queued ids in arrival order
    cts_fifo #(
        .DEPTH  (TABLE_SIZE),
        .DATA_W (IDX_W)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (do_push),
        .push_data (req_idx),
        .pop       (do_start),
        .head_data (fifo_head),
        .empty     (fifo_empty),
        .full      (fifo_full)
    );

    // Opcode decode: response and state update controls
    always_comb
    begin
        do_push       = 1'b0;
        do_start      = 1'b0;
        do_mark_rerun = 1'b0;
        do_rerun      = 1'b0;
        do_stop       = 1'b0;
        rsp_new       = '{status: ST_QUERY, id: task_id, state: TS_IDLE};
        unique case (opcode_t'(opcode))
            OP_SCHEDULE:
            begin
                rsp_new.status = ST_ALREADY;
                if (id_ok)
                begin
                    if (running_hit)
                    begin
                        rsp_new.state = TS_RERUN;
                        if (!rerun_reg)
                        begin
                            rsp_new.status = ST_RERUN_MARKED;
                            do_mark_rerun  = accept;
                        end
                    end
                    else if (queued_hit)
                    begin
                        rsp_new.state = TS_QUEUED;
                    end
                    else if (!fifo_full)
                    begin
                        rsp_new.status = ST_QUEUED;
                        rsp_new.state  = TS_QUEUED;
                        do_push        = accept;
                    end
                end
            end
            OP_START:
            begin
                if (running_valid_reg)
                begin
                    rsp_new = '{status: ST_WORKER_BUSY, id: ID_W'(running_id_reg),
                                state: run_state};
                end
                else if (fifo_empty)
                begin
                    rsp_new = '{status: ST_QUEUE_EMPTY, id: '0, state: TS_IDLE};
                end
                else
                begin
                    rsp_new  = '{status: ST_STARTED, id: ID_W'(fifo_head), state: TS_EXEC};
                    do_start = accept;
                end
            end
            OP_FINISH:
            begin
                if (!running_valid_reg)
                begin
                    rsp_new = '{status: ST_NOTHING_RUN, id: '0, state: TS_IDLE};
                end
                else if (rerun_reg)
                begin
                    rsp_new  = '{status: ST_RERUN, id: ID_W'(running_id_reg), state: TS_EXEC};
                    do_rerun = accept;
                end
                else
                begin
                    rsp_new = '{status: ST_FINISHED, id: ID_W'(running_id_reg), state: TS_IDLE};
                    do_stop = accept;
                end
            end
            OP_QUERY:
            begin
                if (id_ok)
                begin
                    if (running_hit)
                    begin
                        rsp_new.state = run_state;
                    end
                    else if (queued_hit)
                    begin
                        rsp_new.state = TS_QUEUED;
                    end
                end
            end
            default:
            begin
                rsp_new = '{status: ST_QUERY, id: task_id, state: TS_IDLE};
            end
        endcase
    end

    // Queued flags and worker slot
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            queued_reg        <= '0;
            running_valid_reg <= 1'b0;
            rerun_reg         <= 1'b0;
            running_id_reg    <= '0;
        end
        else
        begin
            if (do_push)
            begin
                queued_reg[req_idx] <= 1'b1;
            end
            if (do_start)
            begin
                queued_reg[fifo_head] <= 1'b0;
                running_id_reg        <= fifo_head;
                running_valid_reg     <= 1'b1;
                rerun_reg             <= 1'b0;
            end
            if (do_mark_rerun)
            begin
                rerun_reg <= 1'b1;
            end
            if (do_rerun)
            begin
                rerun_reg <= 1'b0;
            end
            if (do_stop)
            begin
                running_valid_reg <= 1'b0;
            end
        end
    end

    // Response valid flags: output register backed by a one-entry skid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!rsp_valid_reg || !rsp_stall)
        begin
            rsp_valid_reg  <= skid_valid_reg || accept;
            skid_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    // Response payload
    always_ff @(posedge clk)
    begin
        if (!rsp_valid_reg || !rsp_stall)
        begin
            rsp_reg <= skid_valid_reg ? skid_reg : rsp_new;
        end
        else if (accept)
        begin
            skid_reg <= rsp_new;
        end
    end

    assign rsp_valid  = rsp_valid_reg;
    assign status     = rsp_reg.status;
    assign result_id  = rsp_reg.id;
    assign task_state = rsp_reg.state;

endmodule

`default_nettype wire

// File: hdl/cts_fifo.sv
// Show-ahead FIFO of queued task ids with a registered head entry.
`default_nettype none

module cts_fifo #(
    parameter int DEPTH  = 64,
    parameter int DATA_W = 6
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire logic [DATA_W-1:0] push_data,
    input  wire logic              pop,
    output logic      [DATA_W-1:0] head_data,
    output logic                   empty,
    output logic                   full
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [PTR_W-1:0]  head_reg;
    logic [PTR_W-1:0]  head_next;
    logic [PTR_W-1:0]  tail_reg;
    logic [PTR_W-1:0]  tail_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic [DATA_W-1:0] head_data_reg;

    // Pointer advance with wrap at the depth
    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (pop)
        begin
            head_next  = (head_reg == PTR_W'(DEPTH - 1)) ? '0 : head_reg + 1'b1;
            count_next = count_reg - 1'b1;
        end
        if (push)
        begin
            tail_next  = (tail_reg == PTR_W'(DEPTH - 1)) ? '0 : tail_reg + 1'b1;
            count_next = count_reg + 1'b1;
        end
    end

    // Storage write and head prefetch; a push into the next head slot bypasses
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[tail_reg] <= push_data;
        end
        if (push && (tail_reg == head_next))
        begin
            head_data_reg <= push_data;
        end
        else
        begin
            head_data_reg <= mem[head_next];
        end
    end

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    assign head_data = head_data_reg;
    assign empty     = (count_reg == '0);
    assign full      = (count_reg == CNT_W'(DEPTH));

endmodule

`default_nettype wire

// File: tb/testbench.sv
// Self-checking testbench for the coalescing task scheduler: directed table, then random traffic.
`timescale 1ns / 100ps

module testbench;
    import cts_pkg::*;

    localparam int NUM_TASKS      = NUM_TASKS_DEF;
    localparam int DIR_ROWS       = 26;
    localparam int PHASE_ITEMS    = 400;
    localparam int HOLD_CYCLES    = 60;
    localparam int DRAIN_CYCLES   = 8;
    localparam int WATCHDOG_LIMIT = 2000;

    typedef struct packed {
        status_t             status;
        logic [ID_W-1:0]     id;
        task_state_t         state;
    } sched_rsp_t;

    typedef struct packed {
        opcode_t             op;
        logic [ID_W-1:0]     id;
        logic                typed;
        sched_rsp_t          want;
    } sched_row_t;

    logic                clk;
    logic                rst_n;
    logic                req_valid;
    logic                req_stall;
    logic [OP_W-1:0]     opcode;
    logic [ID_W-1:0]     task_id;
    logic                rsp_valid;
    logic                rsp_stall;
    logic [STATUS_W-1:0] status;
    logic [ID_W-1:0]     result_id;
    logic [STATE_W-1:0]  task_state;

    // Mirror of the scheduler: per-id state, queued ids in order, worker slot
    task_state_t         mirror_state [NUM_TASKS];
    logic [ID_W-1:0]     mirror_fifo [$];
    logic [ID_W-1:0]     mirror_run_id;
    logic                mirror_running;

    sched_rsp_t          pending_rsp [$];
    logic                row_typed;
    sched_rsp_t          row_want;

    int                  send_idle_pct;
    int                  rsp_stall_pct;
    int                  hold_left;
    int                  quiet_cycles;
    int                  n_req;
    int                  n_rsp;
    int                  n_err;
    bit                  status_seen [16];

    // Directed rows; rows marked typed carry their expected response
    sched_row_t dir_rows [DIR_ROWS] = '{
        '{OP_QUERY,    6'd0,  1'b1, '{ST_QUERY,       6'd0,  TS_IDLE}},
        '{OP_QUERY,    6'd63, 1'b1, '{ST_QUERY,       6'd63, TS_IDLE}},
        '{OP_START,    6'd0,  1'b1, '{ST_QUEUE_EMPTY, 6'd0,  TS_IDLE}},
        '{OP_FINISH,   6'd63, 1'b1, '{ST_NOTHING_RUN, 6'd0,  TS_IDLE}},
        '{OP_SCHEDULE, 6'd0,  1'b1, '{ST_QUEUED,      6'd0,  TS_QUEUED}},
        '{OP_SCHEDULE, 6'd0,  1'b1, '{ST_ALREADY,     6'd0,  TS_QUEUED}},
        '{OP_SCHEDULE, 6'd63, 1'b0, '0},
        '{OP_START,    6'd42, 1'b0, '0},
        '{OP_START,    6'd0,  1'b0, '0},
        '{OP_SCHEDULE, 6'd0,  1'b0, '0},
        '{OP_SCHEDULE, 6'd0,  1'b0, '0},
        '{OP_QUERY,    6'd0,  1'b0, '0},
        '{OP_FINISH,   6'd0,  1'b0, '0},
        '{OP_FINISH,   6'd0,  1'b0, '0},
        '{OP_FINISH,   6'd0,  1'b1, '{ST_NOTHING_RUN, 6'd0,  TS_IDLE}},
        '{OP_START,    6'd0,  1'b0, '0},
        '{OP_QUERY,    6'd63, 1'b0, '0},
        '{OP_FINISH,   6'd0,  1'b0, '0},
        '{OP_START,    6'd0,  1'b1, '{ST_QUEUE_EMPTY, 6'd0,  TS_IDLE}},
        '{OP_SCHEDULE, 6'd42, 1'b0, '0},
        '{OP_SCHEDULE, 6'd21, 1'b0, '0},
        '{OP_START,    6'd0,  1'b0, '0},
        '{OP_SCHEDULE, 6'd42, 1'b0, '0},
        '{OP_FINISH,   6'd0,  1'b0, '0},
        '{OP_FINISH,   6'd0,  1'b0, '0},
        '{OP_START,    6'd0,  1'b0, '0}
    };

    coalescing_task_scheduler #(
        .NUM_TASKS(NUM_TASKS)
    ) u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .opcode     (opcode),
        .task_id    (task_id),
        .rsp_valid  (rsp_valid),
        .rsp_stall  (rsp_stall),
        .status     (status),
        .result_id  (result_id),
        .task_state (task_state)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Apply one request to the mirror and return the response it should produce
    function automatic sched_rsp_t schedule_step(input opcode_t op, input logic [ID_W-1:0] id);
        sched_rsp_t  r;
        task_state_t cur;
        logic [ID_W-1:0] nid;
        bit id_ok;
        id_ok = int'(id) < NUM_TASKS;
        cur = id_ok ? mirror_state[id] : TS_IDLE;
        case (op)
            OP_SCHEDULE:
            begin
                if (!id_ok)
                    r = '{ST_ALREADY, id, TS_IDLE};
                else if (cur == TS_EXEC)
                begin
                    mirror_state[id] = TS_RERUN;
                    r = '{ST_RERUN_MARKED, id, TS_RERUN};
                end
                else if (cur == TS_IDLE && mirror_fifo.size() < NUM_TASKS)
                begin
                    mirror_fifo.push_back(id);
                    mirror_state[id] = TS_QUEUED;
                    r = '{ST_QUEUED, id, TS_QUEUED};
                end
                else
                    r = '{ST_ALREADY, id, cur};
            end
            OP_START:
            begin
                if (mirror_running)
                    r = '{ST_WORKER_BUSY, mirror_run_id, mirror_state[mirror_run_id]};
                else if (mirror_fifo.size() == 0)
                    r = '{ST_QUEUE_EMPTY, '0, TS_IDLE};
                else
                begin
                    nid = mirror_fifo.pop_front();
                    mirror_state[nid] = TS_EXEC;
                    mirror_run_id = nid;
                    mirror_running = 1'b1;
                    r = '{ST_STARTED, nid, TS_EXEC};
                end
            end
            OP_FINISH:
            begin
                if (!mirror_running)
                    r = '{ST_NOTHING_RUN, '0, TS_IDLE};
                else if (mirror_state[mirror_run_id] == TS_RERUN)
                begin
                    // coalesced requests turn into one more run in place
                    mirror_state[mirror_run_id] = TS_EXEC;
                    r = '{ST_RERUN, mirror_run_id, TS_EXEC};
                end
                else
                begin
                    mirror_state[mirror_run_id] = TS_IDLE;
                    mirror_running = 1'b0;
                    r = '{ST_FINISHED, mirror_run_id, TS_IDLE};
                end
            end
            default:
                r = '{ST_QUERY, id, cur};
        endcase
        return r;
    endfunction

    // Accept monitor, response checker and idle counter for the watchdog
    always @(posedge clk)
    begin
        sched_rsp_t want;
        sched_rsp_t pred;
        if (rst_n && req_valid && !req_stall)
        begin
            pred = schedule_step(opcode_t'(opcode), task_id);
            pending_rsp.push_back(row_typed ? row_want : pred);
            n_req++;
        end
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            n_rsp++;
            if (pending_rsp.size() == 0)
            begin
                $display("%0t: response beat with nothing expected: status %0d id %0d state %0d",
                         $time, status, result_id, task_state);
                n_err++;
            end
            else
            begin
                want = pending_rsp.pop_front();
                status_seen[want.status] = 1'b1;
                if (status !== want.status)
                begin
                    $display("%0t: status expected %0d actual %0d", $time, want.status, status);
                    n_err++;
                end
                if (result_id !== want.id)
                begin
                    $display("%0t: result_id expected %0d actual %0d", $time, want.id, result_id);
                    n_err++;
                end
                if (task_state !== want.state)
                begin
                    $display("%0t: task_state expected %0d actual %0d",
                             $time, want.state, task_state);
                    n_err++;
                end
            end
        end
        if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin : watchdog
        wait (quiet_cycles >= WATCHDOG_LIMIT);
        $display("%0t: no beat accepted for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("TEST FAILED");
        $finish;
    end

    // Receiver: random stall, or a counted hold-off when one is requested
    initial
    begin : rsp_side
        rsp_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                rsp_stall = 1'b1;
                hold_left--;
            end
            else
                rsp_stall = ($urandom_range(99) < rsp_stall_pct);
        end
    end

    // Offer one request beat and hold it until it is taken
    task automatic send_req(input opcode_t op, input logic [ID_W-1:0] id,
                            input logic typed, input sched_rsp_t want);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_valid = 1'b0;
            @(negedge clk);
        end
        req_valid = 1'b1;
        opcode    = op;
        task_id   = id;
        row_typed = typed;
        row_want  = want;
        do
            @(posedge clk);
        while (req_stall);
    endtask

    // Random requests; a flood first schedules every id once so the queue fills
    task automatic run_random(input int count, input bit flood);
        int base;
        int pick;
        opcode_t op;
        logic [ID_W-1:0] id;
        base = $urandom_range(ID_SPACE - 1);
        for (int i = 0; i < count; i++)
        begin
            if (flood && i < ID_SPACE)
            begin
                op = OP_SCHEDULE;
                id = ID_W'(base + i);
            end
            else
            begin
                pick = $urandom_range(99);
                if (pick < 40)
                    op = OP_SCHEDULE;
                else if (pick < 65)
                    op = OP_START;
                else if (pick < 90)
                    op = OP_FINISH;
                else
                    op = OP_QUERY;
                // a small id pool makes coalescing and repeats common
                if ($urandom_range(1) == 1)
                    id = ID_W'($urandom_range(7));
                else
                    id = ID_W'($urandom_range(ID_SPACE - 1));
            end
            send_req(op, id, 1'b0, '0);
        end
    endtask

    initial
    begin : stimulus
        req_valid      = 1'b0;
        opcode         = OP_SCHEDULE;
        task_id        = '0;
        row_typed      = 1'b0;
        row_want       = '0;
        send_idle_pct  = 0;
        rsp_stall_pct  = 0;
        hold_left      = 0;
        quiet_cycles   = 0;
        n_req          = 0;
        n_rsp          = 0;
        n_err          = 0;
        mirror_running = 1'b0;
        mirror_run_id  = '0;
        foreach (mirror_state[i])
            mirror_state[i] = TS_IDLE;
        foreach (status_seen[i])
            status_seen[i] = 1'b0;
        rst_n = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed table
        for (int r = 0; r < DIR_ROWS; r++)
            send_req(dir_rows[r].op, dir_rows[r].id, dir_rows[r].typed, dir_rows[r].want);

        // idling phases: none, sender idle, receiver stalling, both a little
        for (int ph = 0; ph < 4; ph++)
        begin
            send_idle_pct = (ph == 1) ? 72 : (ph == 3) ? 15 : 0;
            rsp_stall_pct = (ph == 2) ? 72 : (ph == 3) ? 15 : 0;
            run_random(PHASE_ITEMS, ph == 1 || ph == 3);
        end

        // back-pressure: receiver holds off while the sender keeps offering
        send_idle_pct = 0;
        rsp_stall_pct = 0;
        hold_left     = HOLD_CYCLES;
        run_random(100, 1'b0);

        @(negedge clk);
        req_valid = 1'b0;
        while (pending_rsp.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        begin
            int n_codes;
            n_codes = 0;
            foreach (status_seen[i])
                n_codes += status_seen[i];
            $display("Ran %0d request beats and checked %0d response beats, %0d mismatches.",
                     n_req, n_rsp, n_err);
            $display("Saw %0d of 10 status codes under four idling mixes and a %0d-cycle hold-off.",
                     n_codes, HOLD_CYCLES);
        end
        if (n_err == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
